// ===== design/khop_pkg.sv =====
// ---------------------------------------------------------------------------
// k-hop neighbour search package
// Shared codes and types for the k-hop breadth-first search block.
// ---------------------------------------------------------------------------
package khop_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_RUN   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_UNDIRECTED = 2'd0,
    REG_HOP_COUNT  = 2'd1,
    REG_LIMIT      = 2'd2,
    REG_LABEL_MASK = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR_MAP,
    ST_LEVEL,
    ST_FETCH_V,
    ST_WAIT_V,
    ST_EDGE_RD,
    ST_EDGE_WAIT,
    ST_EDGE_CHK,
    ST_MAP_WAIT,
    ST_MAP_CHK,
    ST_LEVEL_END,
    ST_EMIT,
    ST_FINISH
  } state_t;

  localparam int unsigned MAX_ITEMS   = 63;
  localparam int unsigned LABEL_LIMIT = 16;

endpackage

// ===== design/k_hop_neighbor_bfs.sv =====
// ---------------------------------------------------------------------------
// k-hop neighbour search
// Stores a labelled edge list and walks it breadth first to report vertices
// at exactly the configured hop distance from a start vertex.
// ---------------------------------------------------------------------------
// A load is answered the cycle after its transfer and the block is ready again
// once that answer is taken. A query first clears the visited map, one vertex a
// cycle, then for every frontier vertex, enabled direction and allowed label
// sweeps the edge store, with an extra visited-map lookup for every hit.
// A vertex is sent once the next is found or the walk ends; reset empties the store.
module k_hop_neighbor_bfs #(
  parameter int VERTEX_COUNT  = 64,
  parameter int EDGE_CAPACITY = 256,
  parameter int LABEL_COUNT   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[1:0], edge_source[7:2], edge_target[13:8], edge_label[17:14],
  // start_vertex[23:18]
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // found_vertex[5:0], has_vertex[6], edge_dropped[7]
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int VW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int EW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
  localparam int CW = $clog2(EDGE_CAPACITY + 1);
  localparam int QW = $clog2(VERTEX_COUNT + 1);
  localparam int NL = (LABEL_COUNT < 16) ? LABEL_COUNT : 16;

  khop_pkg::state_t state, state_next;

  logic        undirected_mode;
  logic [6:0]  hop_count;
  logic [7:0]  result_limit;
  logic [15:0] label_mask;

  logic [5:0] edge_sources [EDGE_CAPACITY];
  logic [5:0] edge_targets [EDGE_CAPACITY];
  logic [3:0] edge_labels  [EDGE_CAPACITY];
  logic [CW-1:0] edges_stored;

  logic       visited_map [VERTEX_COUNT];
  logic [5:0] queue_mem   [2*VERTEX_COUNT];

  logic [1:0] action;
  logic [5:0] in_src, in_tgt, in_start;
  logic [3:0] in_lab;
  assign action   = s_tdata[1:0];
  assign in_src   = s_tdata[7:2];
  assign in_tgt   = s_tdata[13:8];
  assign in_lab   = s_tdata[17:14];
  assign in_start = s_tdata[23:18];

  logic        cur;
  logic [QW-1:0] qsz, nsz, qi;
  logic [6:0]  hops;
  logic [5:0]  limit, found;
  logic [VW-1:0] vtx, cvtx;
  logic        dir;
  logic [3:0]  lab;
  logic [CW-1:0] eidx;
  logic [5:0]  rd_src, rd_tgt, rd_q, to_v;
  logic [3:0]  rd_lab;
  logic        rd_vis;
  logic [5:0]  out_v;
  logic        out_has, out_last, out_drop, emit_last;
  logic [5:0]  in_start_r;
  logic [5:0]  hold_v;

  logic accept;
  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == khop_pkg::ST_IDLE) && !m_tvalid;

  assign m_tdata = {out_drop, out_has, out_v};
  assign m_tlast = out_last;

  logic [5:0] from_v, cand_v;
  logic       edge_hit, cand_ok, more_edges;
  assign from_v = dir ? rd_src : rd_tgt;
  assign cand_v = dir ? rd_tgt : rd_src;
  assign edge_hit = (rd_lab == lab) && (from_v == 6'(cvtx)) &&
                    (32'(cand_v) < VERTEX_COUNT);
  assign more_edges = (32'(eidx) + 1 < 32'(edges_stored));
  assign cand_ok = !rd_vis;

  // A new vertex at the target distance, and whether an earlier one is sent now.
  logic take_v, pass_held;
  assign take_v = (state == khop_pkg::ST_MAP_CHK) && cand_ok && (hops == 7'd1);
  assign pass_held = take_v && (found != '0);

  // Next label with mask set, or end of direction.
  logic       nxt_lab_valid;
  logic [3:0] nxt_lab;
  always_comb begin
    nxt_lab_valid = 1'b0;
    nxt_lab = '0;
    for (int i = NL - 1; i >= 0; i--) begin
      if (i > int'(lab) && label_mask[i]) begin
        nxt_lab_valid = 1'b1;
        nxt_lab = 4'(i);
      end
    end
  end

  logic       first_lab_valid;
  logic [3:0] first_lab;
  always_comb begin
    first_lab_valid = 1'b0;
    first_lab = '0;
    for (int i = NL - 1; i >= 0; i--) begin
      if (label_mask[i]) begin
        first_lab_valid = 1'b1;
        first_lab = 4'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      undirected_mode <= 1'b0;
      hop_count <= 7'd1;
      result_limit <= 8'hFF;
      label_mask <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (khop_pkg::reg_index_t'(cfg_index))
        khop_pkg::REG_UNDIRECTED: undirected_mode <= cfg_data[0];
        khop_pkg::REG_HOP_COUNT:  hop_count <= cfg_data[6:0];
        khop_pkg::REG_LIMIT:      result_limit <= cfg_data[7:0];
        khop_pkg::REG_LABEL_MASK: label_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Edge store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (accept && action == khop_pkg::ACT_LOAD && 32'(edges_stored) < EDGE_CAPACITY) begin
      edge_sources[EW'(edges_stored)] <= in_src;
      edge_targets[EW'(edges_stored)] <= in_tgt;
      edge_labels[EW'(edges_stored)]  <= in_lab;
    end
    rd_src <= edge_sources[EW'(eidx)];
    rd_tgt <= edge_targets[EW'(eidx)];
    rd_lab <= edge_labels[EW'(eidx)];
  end

  logic map_we, map_wd;
  logic [VW-1:0] map_wa;
  always_comb begin
    map_we = 1'b0;
    map_wd = 1'b0;
    map_wa = vtx;
    if (state == khop_pkg::ST_CLEAR_MAP) begin
      map_we = 1'b1;
      map_wd = (vtx == VW'(in_start_r));
    end else if (state == khop_pkg::ST_MAP_CHK && cand_ok) begin
      map_we = 1'b1;
      map_wd = 1'b1;
      map_wa = VW'(to_v);
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) visited_map[map_wa] <= map_wd;
    rd_vis <= visited_map[VW'(cand_v)];
  end

  logic q_we;
  always_comb q_we = (state == khop_pkg::ST_MAP_CHK) && cand_ok && (hops != 7'd1) &&
                     (32'(nsz) < VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (state == khop_pkg::ST_IDLE)
      queue_mem[{1'b0, VW'(0)}] <= in_start;
    else if (q_we)
      queue_mem[{~cur, VW'(nsz)}] <= to_v;
    rd_q <= queue_mem[{cur, VW'(qi)}];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      khop_pkg::ST_IDLE: begin
        if (accept && action == khop_pkg::ACT_LOAD) state_next = khop_pkg::ST_EMIT;
        else if (accept && action == khop_pkg::ACT_RUN) begin
          if (32'(in_start) >= VERTEX_COUNT || hop_count == 7'd0)
            state_next = khop_pkg::ST_FINISH;
          else state_next = khop_pkg::ST_CLEAR_MAP;
        end
      end
      khop_pkg::ST_CLEAR_MAP:
        if (32'(vtx) == VERTEX_COUNT - 1) state_next = khop_pkg::ST_LEVEL;
      khop_pkg::ST_LEVEL:
        if (hops == 7'd0 || qsz == '0) state_next = khop_pkg::ST_FINISH;
        else state_next = khop_pkg::ST_FETCH_V;
      khop_pkg::ST_FETCH_V: begin
        if (qi == qsz) state_next = khop_pkg::ST_LEVEL_END;
        else state_next = khop_pkg::ST_WAIT_V;
      end
      khop_pkg::ST_WAIT_V: begin
        if (!first_lab_valid || edges_stored == '0) state_next = khop_pkg::ST_FETCH_V;
        else state_next = khop_pkg::ST_EDGE_RD;
      end
      khop_pkg::ST_EDGE_RD:   state_next = khop_pkg::ST_EDGE_WAIT;
      khop_pkg::ST_EDGE_WAIT: state_next = khop_pkg::ST_EDGE_CHK;
      khop_pkg::ST_EDGE_CHK: begin
        if (edge_hit) state_next = khop_pkg::ST_MAP_WAIT;
        else if (more_edges || nxt_lab_valid || !dir) state_next = khop_pkg::ST_EDGE_RD;
        else state_next = khop_pkg::ST_FETCH_V;
      end
      khop_pkg::ST_MAP_WAIT: state_next = khop_pkg::ST_MAP_CHK;
      khop_pkg::ST_MAP_CHK: begin
        if (pass_held) state_next = khop_pkg::ST_EMIT;
        else if (take_v && emit_last) state_next = khop_pkg::ST_FINISH;
        else if (more_edges || nxt_lab_valid || !dir) state_next = khop_pkg::ST_EDGE_RD;
        else state_next = khop_pkg::ST_FETCH_V;
      end
      khop_pkg::ST_EMIT: begin
        if (m_tvalid && m_tready) begin
          if (out_last) state_next = khop_pkg::ST_IDLE;
          else if (found >= limit) state_next = khop_pkg::ST_FINISH;
          else if (more_edges || nxt_lab_valid || !dir) state_next = khop_pkg::ST_EDGE_RD;
          else state_next = khop_pkg::ST_FETCH_V;
        end
      end
      khop_pkg::ST_LEVEL_END: state_next = khop_pkg::ST_LEVEL;
      khop_pkg::ST_FINISH:
        if (m_tvalid && m_tready) state_next = khop_pkg::ST_IDLE;
      default: state_next = khop_pkg::ST_IDLE;
    endcase
  end

  assign emit_last = (found + 6'd1 >= limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= khop_pkg::ST_IDLE;
      edges_stored <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        khop_pkg::ST_IDLE: begin
          in_start_r <= in_start;
          vtx <= '0;
          found <= '0;
          hops <= hop_count;
          qsz <= QW'(1);
          cur <= 1'b0;
          if (result_limit[7]) limit <= 6'(khop_pkg::MAX_ITEMS);
          else if (result_limit == 8'd0) limit <= 6'd1;
          else if (32'(result_limit) < khop_pkg::MAX_ITEMS) limit <= result_limit[5:0];
          else limit <= 6'(khop_pkg::MAX_ITEMS);
          if (accept) begin
            unique case (khop_pkg::action_t'(action))
              khop_pkg::ACT_LOAD: begin
                out_v <= '0; out_has <= 1'b0; out_last <= 1'b1;
                out_drop <= !(32'(edges_stored) < EDGE_CAPACITY);
                if (32'(edges_stored) < EDGE_CAPACITY) edges_stored <= edges_stored + 1'b1;
                m_tvalid <= 1'b1;
              end
              khop_pkg::ACT_CLEAR: edges_stored <= '0;
              default: ;
            endcase
          end
        end
        khop_pkg::ST_CLEAR_MAP: vtx <= vtx + 1'b1;
        khop_pkg::ST_LEVEL: begin
          qi <= '0;
          nsz <= '0;
        end
        khop_pkg::ST_FETCH_V: ;
        khop_pkg::ST_WAIT_V: begin
          cvtx <= VW'(rd_q);
          qi <= qi + 1'b1;
          dir <= !undirected_mode;
          lab <= first_lab;
          eidx <= '0;
        end
        khop_pkg::ST_EDGE_CHK, khop_pkg::ST_MAP_CHK: begin
          if (state == khop_pkg::ST_EDGE_CHK && edge_hit) begin
            to_v <= cand_v;
          end else if (!pass_held) begin
            if (more_edges) eidx <= eidx + 1'b1;
            else begin
              eidx <= '0;
              if (nxt_lab_valid) lab <= nxt_lab;
              else begin
                dir <= 1'b1;
                lab <= first_lab;
              end
            end
          end
          if (q_we) nsz <= nsz + 1'b1;
          if (take_v) begin
            hold_v <= to_v;
            found <= found + 6'd1;
            if (pass_held) begin
              out_v <= hold_v; out_has <= 1'b1; out_drop <= 1'b0; out_last <= 1'b0;
              m_tvalid <= 1'b1;
            end
          end
        end
        khop_pkg::ST_EMIT: begin
          if (m_tvalid && m_tready && out_has) begin
            if (more_edges) eidx <= eidx + 1'b1;
            else begin
              eidx <= '0;
              if (nxt_lab_valid) lab <= nxt_lab;
              else begin
                dir <= 1'b1;
                lab <= first_lab;
              end
            end
          end
        end
        khop_pkg::ST_LEVEL_END: begin
          hops <= hops - 7'd1;
          cur <= ~cur;
          qsz <= nsz;
        end
        khop_pkg::ST_FINISH: begin
          if (!m_tvalid) begin
            out_v <= (found == '0) ? 6'd0 : hold_v;
            out_has <= (found != '0);
            out_drop <= 1'b0;
            out_last <= 1'b1;
            m_tvalid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// k-hop neighbour search testbench
// Drives load, clear and query transfers into the block and predicts every
// result with an independent breadth-first walk over a mirrored edge store.
// Both stream sides stall at random, and the registers are varied between
// phases while the block is idle.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0] vertex;
    logic       has;
    logic       last;
    logic       dropped;
  } walk_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  k_hop_neighbor_bfs dut (.*);

  always #10 clk = ~clk;

  walk_result_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int unsigned cycle_count = 0;

  logic [5:0] mirror_src [256];
  logic [5:0] mirror_tgt [256];
  logic [3:0] mirror_lab [256];
  int         mirror_count = 0;
  logic       undirected = 1'b0;
  logic [6:0] hops_cfg = 7'd1;
  logic [7:0] limit_cfg = 8'hFF;
  logic [15:0] mask_cfg = 16'hFFFF;

  function automatic void push_result(logic [5:0] v, logic h, logic l, logic d);
    walk_result_t r;
    r.vertex = v;
    r.has = h;
    r.last = l;
    r.dropped = d;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void predict_walk(logic [5:0] start);
    logic [63:0] visited;
    logic [5:0]  frontier [2][64];
    int cur, qsz, nsz, hops, found, limit, from, to, first_dir;
    found = 0;
    limit = khop_pkg::MAX_ITEMS;
    if (!limit_cfg[7]) begin
      limit = (limit_cfg == 0) ? 1 :
              ((limit_cfg < khop_pkg::MAX_ITEMS) ? limit_cfg : khop_pkg::MAX_ITEMS);
    end
    hops = hops_cfg;
    if (hops == 0) begin
      push_result(6'd0, 1'b0, 1'b1, 1'b0);
      return;
    end
    visited = '0;
    visited[start] = 1'b1;
    frontier[0][0] = start;
    cur = 0;
    qsz = 1;
    nsz = 0;
    first_dir = undirected ? 0 : 1;
    while (hops != 0 && qsz != 0) begin
      for (int i = 0; i < qsz; i++) begin
        for (int d = first_dir; d <= 1; d++) begin
          for (int lab = 0; lab < khop_pkg::LABEL_LIMIT; lab++) begin
            if (mask_cfg[lab]) begin
              for (int e = 0; e < mirror_count; e++) begin
                if (mirror_lab[e] == lab) begin
                  from = d ? mirror_src[e] : mirror_tgt[e];
                  to   = d ? mirror_tgt[e] : mirror_src[e];
                  if (from == frontier[cur][i] && !visited[to]) begin
                    visited[to] = 1'b1;
                    if (hops == 1) begin
                      push_result(to[5:0], 1'b1, 1'b0, 1'b0);
                      found++;
                      if (found >= limit) begin
                        pending_results[pending_results.size() - 1].last = 1'b1;
                        return;
                      end
                    end else if (nsz < 64) begin
                      frontier[cur ^ 1][nsz] = to[5:0];
                      nsz++;
                    end
                  end
                end
              end
            end
          end
        end
      end
      hops--;
      cur ^= 1;
      qsz = nsz;
      nsz = 0;
    end
    if (found == 0) begin
      push_result(6'd0, 1'b0, 1'b1, 1'b0);
    end else begin
      pending_results[pending_results.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void predict_item(logic [23:0] d);
    khop_pkg::action_t act;
    act = khop_pkg::action_t'(d[1:0]);
    case (act)
      khop_pkg::ACT_LOAD: begin
        if (mirror_count < 256) begin
          mirror_src[mirror_count] = d[7:2];
          mirror_tgt[mirror_count] = d[13:8];
          mirror_lab[mirror_count] = d[17:14];
          mirror_count++;
          push_result(6'd0, 1'b0, 1'b1, 1'b0);
        end else begin
          push_result(6'd0, 1'b0, 1'b1, 1'b1);
        end
      end
      khop_pkg::ACT_CLEAR: mirror_count = 0;
      khop_pkg::ACT_RUN: predict_walk(d[23:18]);
      default: ;
    endcase
  endfunction

  task automatic send_item(khop_pkg::action_t act, int src, int tgt, int lab, int start);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {start[5:0], lab[3:0], tgt[5:0], src[5:0], act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(s_tdata);
    items_sent++;
  endtask

  task automatic wait_idle();
    if (s_tvalid) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(khop_pkg::reg_index_t idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      khop_pkg::REG_UNDIRECTED: undirected = value[0];
      khop_pkg::REG_HOP_COUNT:  hops_cfg = value[6:0];
      khop_pkg::REG_LIMIT:      limit_cfg = value[7:0];
      default:                  mask_cfg = value[15:0];
    endcase
  endtask

  task automatic set_regs(int und, int hops, int lim, int mask);
    wait_idle();
    write_reg(khop_pkg::REG_UNDIRECTED, und);
    write_reg(khop_pkg::REG_HOP_COUNT, hops);
    write_reg(khop_pkg::REG_LIMIT, lim & 8'hFF);
    write_reg(khop_pkg::REG_LABEL_MASK, mask);
  endtask

  always @(posedge clk) begin
    walk_result_t exp_r;
    cycle_count++;
    if (cycle_count > 20000000) begin
      $display("Verification failed");
      $finish;
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual data %h last %b",
                 $time, m_tdata, m_tlast);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata !== {exp_r.dropped, exp_r.has, exp_r.vertex} || m_tlast !== exp_r.last) begin
          errors++;
          $display("%0t: mismatch, expected vertex %0d has %b dropped %b last %b,",
                   $time, exp_r.vertex, exp_r.has, exp_r.dropped, exp_r.last);
          $display("%0t:   actual vertex %0d has %b dropped %b last %b",
                   $time, m_tdata[5:0], m_tdata[6], m_tdata[7], m_tlast);
        end
      end
    end
  end

  task automatic test_empty_store();
    send_item(khop_pkg::ACT_RUN, 0, 0, 0, 0);
    send_item(khop_pkg::ACT_RUN, 0, 0, 0, 63);
    send_item(khop_pkg::ACT_NONE, 63, 63, 15, 63);
  endtask

  task automatic test_directed_walk();
    send_item(khop_pkg::ACT_LOAD, 0, 1, 0, 0);
    send_item(khop_pkg::ACT_LOAD, 1, 2, 15, 0);
    send_item(khop_pkg::ACT_LOAD, 0, 3, 5, 0);
    send_item(khop_pkg::ACT_LOAD, 63, 0, 3, 0);
    send_item(khop_pkg::ACT_LOAD, 2, 63, 10, 0);
    send_item(khop_pkg::ACT_RUN, 0, 0, 0, 0);
    set_regs(0, 2, -1, 16'hFFFF);
    send_item(khop_pkg::ACT_RUN, 0, 0, 0, 0);
    set_regs(1, 1, -1, 16'hFFFF);
    send_item(khop_pkg::ACT_RUN, 0, 0, 0, 0);
    set_regs(1, 1, 0, 16'h8021);
    send_item(khop_pkg::ACT_RUN, 0, 0, 0, 0);
    set_regs(1, 64, 64, 16'h0000);
    send_item(khop_pkg::ACT_RUN, 0, 0, 0, 2);
    set_regs(1, 64, 1, 16'hFFFF);
    send_item(khop_pkg::ACT_RUN, 0, 0, 0, 2);
    set_regs(0, 0, -128, 16'hFFFF);
    send_item(khop_pkg::ACT_RUN, 0, 0, 0, 0);
    send_item(khop_pkg::ACT_CLEAR, 0, 0, 0, 0);
    set_regs(1, 1, -1, 16'hFFFF);
    send_item(khop_pkg::ACT_RUN, 0, 0, 0, 0);
  endtask

  task automatic test_full_store();
    set_regs(0, 1, -1, 16'h0002);
    for (int i = 0; i < 258; i++) begin
      send_item(khop_pkg::ACT_LOAD, i % 64, (i * 7) % 64, i % 16, 0);
    end
    send_item(khop_pkg::ACT_RUN, 0, 0, 0, 1);
    send_item(khop_pkg::ACT_CLEAR, 0, 0, 0, 0);
  endtask

  task automatic test_random_phase(int send_pct, int recv_pct);
    int sel, vmax;
    wait_idle();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int p = 0; p < 3; p++) begin
      sel = $urandom_range(3);
      set_regs($urandom_range(1),
               (sel == 0) ? 0 : ((sel == 1) ? 64 : $urandom_range(1, 4)),
               ($urandom_range(2) == 0) ? -1 : $urandom_range(0, 64),
               ($urandom_range(1) == 0) ? 16'hFFFF : $urandom_range(16'hFFFF));
      for (int i = 0; i < 12; i++) begin
        vmax = ($urandom_range(7) == 0) ? 63 : 11;
        sel = $urandom_range(99);
        if (mirror_count > 24 || sel < 4) begin
          send_item(khop_pkg::ACT_CLEAR, $urandom_range(63), $urandom_range(63),
                    $urandom_range(15), 0);
        end else if (sel < 7) begin
          send_item(khop_pkg::ACT_NONE, $urandom_range(63), $urandom_range(63),
                    $urandom_range(15), $urandom_range(63));
        end else if (sel < 80) begin
          send_item(khop_pkg::ACT_LOAD, $urandom_range(vmax), $urandom_range(vmax),
                    $urandom_range(15), $urandom_range(63));
        end else begin
          send_item(khop_pkg::ACT_RUN, $urandom_range(63), $urandom_range(63),
                    $urandom_range(15), $urandom_range(vmax));
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_store();
    test_directed_walk();
    test_full_store();
    test_random_phase(26, 61);
    test_random_phase(61, 26);
    test_random_phase(0, 0);
    wait_idle();
    repeat (100) @(posedge clk);
    $display("Run covered %0d input transfers and %0d result transfers,", items_sent,
             results_seen);
    $display("including a full edge store, both walk modes and the register extremes.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/khop_pkg.sv
design/k_hop_neighbor_bfs.sv
verif/testbench.sv
